@@ sv/dccrc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Dual CRC byte engine package
// Shared payload types, request and register codes, and CRC constants.
// ----------------------------------------------------------------------------
package dccrc_pkg;

    localparam int CRC16_W = 16;
    localparam int CRC32_W = 32;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 32;

    localparam logic [CRC16_W-1:0] CRC16_INIT       = 16'hFFFF;
    localparam logic [CRC32_W-1:0] CRC32_INIT       = 32'hFFFF_FFFF;
    localparam logic [CRC16_W-1:0] CRC16_XOROUT     = 16'hFFFF;
    localparam logic [CRC32_W-1:0] CRC32_XOROUT     = 32'hFFFF_FFFF;
    localparam logic [CRC16_W-1:0] POLY16_RESET     = 16'h1021;
    localparam logic [CRC32_W-1:0] POLY32_RESET     = 32'hEDB8_8320;

    localparam logic REQ_DATA   = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam logic CFG_POLY16 = 1'b0;
    localparam logic CFG_POLY32 = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [CRC16_W-1:0] crc16_final;
        logic [CRC16_W-1:0] crc16_raw;
        logic [CRC32_W-1:0] crc32_final;
        logic [CRC32_W-1:0] crc32_raw;
    } t_out;

endpackage
`default_nettype wire

@@ sv/dual_crc16_crc32_byte_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Dual CRC-16 / CRC-32 byte engine
// Runs reflected CRC-16 and CRC-32 side by side over a byte stream.
// ----------------------------------------------------------------------------
// Each accepted item is either a data byte, folded into both CRCs, or a
// finish request, which emits one result with both CRCs raw and inverted and
// then returns both CRCs to all ones. The block takes one item per cycle: an
// item sits in the input register while the eight-step fold updates the
// CRC registers, and a finish result then waits in the output register.
// A finish item stalls only while an earlier result is still held there.
// Polynomials are to be written through the configuration port only while idle; the block does not enforce it.
module dual_crc16_crc32_byte_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire dccrc_pkg::t_in                i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output dccrc_pkg::t_out                    o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [dccrc_pkg::CFG_W-1:0]   i_cfg_wdata
);

    logic                            r_in_valid, n_in_valid;
    dccrc_pkg::t_in                  r_in, n_in;
    logic                            r_out_valid, n_out_valid;
    dccrc_pkg::t_out                 r_out, n_out;
    logic [dccrc_pkg::CRC16_W-1:0]   r_crc16, n_crc16;
    logic [dccrc_pkg::CRC32_W-1:0]   r_crc32, n_crc32;
    logic [dccrc_pkg::CRC16_W-1:0]   r_poly16, n_poly16;
    logic [dccrc_pkg::CRC32_W-1:0]   r_poly32, n_poly32;

    logic [dccrc_pkg::CRC16_W-1:0]   w_fold16;
    logic [dccrc_pkg::CRC32_W-1:0]   w_fold32;
    logic                            w_stage_fin;
    logic                            w_advance;

    dccrc_fold #(
        .WIDTH (dccrc_pkg::CRC16_W)
    ) u_fold16 (
        .i_crc  (r_crc16),
        .i_poly (r_poly16),
        .i_byte (r_in.data_byte),
        .o_crc  (w_fold16)
    );

    dccrc_fold #(
        .WIDTH (dccrc_pkg::CRC32_W)
    ) u_fold32 (
        .i_crc  (r_crc32),
        .i_poly (r_poly32),
        .i_byte (r_in.data_byte),
        .o_crc  (w_fold32)
    );

    assign w_stage_fin = r_in_valid && (r_in.req_type == dccrc_pkg::REQ_FINISH);
    assign w_advance   = r_in_valid && (!w_stage_fin || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_in_valid = r_in_valid;
        n_in       = r_in;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
            n_in       = i_in_data;
        end
    end

    always_comb begin
        n_crc16 = r_crc16;
        n_crc32 = r_crc32;
        if (w_advance) begin
            if (w_stage_fin) begin
                n_crc16 = dccrc_pkg::CRC16_INIT;
                n_crc32 = dccrc_pkg::CRC32_INIT;
            end else begin
                n_crc16 = w_fold16;
                n_crc32 = w_fold32;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_advance && w_stage_fin) begin
            n_out_valid       = 1'b1;
            n_out.crc16_final = r_crc16 ^ dccrc_pkg::CRC16_XOROUT;
            n_out.crc16_raw   = r_crc16;
            n_out.crc32_final = r_crc32 ^ dccrc_pkg::CRC32_XOROUT;
            n_out.crc32_raw   = r_crc32;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        n_poly16 = r_poly16;
        n_poly32 = r_poly32;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                dccrc_pkg::CFG_POLY16: n_poly16 = i_cfg_wdata[dccrc_pkg::CRC16_W-1:0];
                dccrc_pkg::CFG_POLY32: n_poly32 = i_cfg_wdata[dccrc_pkg::CRC32_W-1:0];
                default: begin
                    n_poly16 = r_poly16;
                    n_poly32 = r_poly32;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_crc16     <= dccrc_pkg::CRC16_INIT;
            r_crc32     <= dccrc_pkg::CRC32_INIT;
            r_poly16    <= dccrc_pkg::POLY16_RESET;
            r_poly32    <= dccrc_pkg::POLY32_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_crc16     <= n_crc16;
            r_crc32     <= n_crc32;
            r_poly16    <= n_poly16;
            r_poly32    <= n_poly32;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_fin_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_stage_fin) |=>
            (r_crc16 == dccrc_pkg::CRC16_INIT) && (r_crc32 == dccrc_pkg::CRC32_INIT))
        else $error("CRC registers not reinitialized after a finish transaction");

    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_stage_fin) |=>
            o_out_valid && (o_out_data.crc32_raw == $past(r_crc32))
            && (o_out_data.crc16_raw == $past(r_crc16)))
        else $error("Finish transaction did not load the result register");

    a_stall_only_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (w_stage_fin && o_out_valid && !i_out_ready))
        else $error("Input stalled without a blocked finish transaction");
`endif

endmodule
`default_nettype wire

@@ sv/dccrc_fold.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Reflected CRC byte fold
// Folds one byte into a reflected CRC register, eight right shifts LSB first.
// ----------------------------------------------------------------------------
module dccrc_fold #(
    parameter int WIDTH = dccrc_pkg::CRC32_W
) (
    input  wire logic [WIDTH-1:0]              i_crc,
    input  wire logic [WIDTH-1:0]              i_poly,
    input  wire logic [dccrc_pkg::BYTE_W-1:0]  i_byte,
    output logic      [WIDTH-1:0]              o_crc
);

    always_comb begin
        logic [WIDTH-1:0] v_reg;
        v_reg = i_crc ^ {{(WIDTH-dccrc_pkg::BYTE_W){1'b0}}, i_byte};
        for (int k = 0; k < dccrc_pkg::BYTE_W; k++) begin
            if (v_reg[0]) begin
                v_reg = (v_reg >> 1) ^ i_poly;
            end else begin
                v_reg = v_reg >> 1;
            end
        end
        o_crc = v_reg;
    end

endmodule
`default_nettype wire
